// ===== rtl/icdo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icdo_pkg: shared types and constants of the integer calculator
// Holds the channel word types, the command handed from the front end to the
// execution unit, operator and command codes, and the text tables.
// ----------------------------------------------------------------------------
package icdo_pkg;

    // Request word: two signed operands and an operator byte.
    typedef struct packed {
        logic signed [31:0] first_operand;
        logic signed [31:0] second_operand;
        logic [7:0]         func;
    } req_word_t;

    // Answer word: one character of the answer text.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } chr_word_t;

    // Operator bytes.
    localparam logic [7:0] OP_ADD = 8'h2B;  // '+'
    localparam logic [7:0] OP_SUB = 8'h2D;  // '-'
    localparam logic [7:0] OP_MUL = 8'h2A;  // '*'
    localparam logic [7:0] OP_DIV = 8'h2F;  // '/'
    localparam logic [7:0] OP_MOD = 8'h25;  // '%'

    // Characters used in the answer text.
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Command kinds, decided by the front end.
    localparam logic [2:0] K_ADD  = 3'd0;
    localparam logic [2:0] K_SUB  = 3'd1;
    localparam logic [2:0] K_MUL  = 3'd2;
    localparam logic [2:0] K_DIV  = 3'd3;
    localparam logic [2:0] K_MOD  = 3'd4;
    localparam logic [2:0] K_DIVZ = 3'd5;
    localparam logic [2:0] K_MODZ = 3'd6;
    localparam logic [2:0] K_BAD  = 3'd7;

    // Classified command held in the queue.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
    } cmd_t;

    // Command queue depth and pointer width.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    // Decimal conversion: at most ten digits; ceil(2^35 / 10) gives an exact
    // quotient for every 32-bit value when the product is shifted by 35.
    localparam int          DIG_MAX  = 10;
    localparam logic [32:0] RECIP10  = 33'h0_CCCC_CCCD;
    localparam int          RECIP_SH = 35;

    // Stop messages.
    localparam int DIV_MSG_LEN = 23;
    localparam int MOD_MSG_LEN = 21;
    localparam logic [8*DIV_MSG_LEN-1:0] DIV_MSG = "Stop : division by zero";
    localparam logic [8*MOD_MSG_LEN-1:0] MOD_MSG = "Stop : modulo by zero";

    // Returns one character of a stop message, first character at index 0.
    function automatic logic [7:0] msg_char(input logic is_mod, input logic [4:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (is_mod)
        begin
            if (int'(idx) < MOD_MSG_LEN)
            begin
                ch = MOD_MSG[8*(MOD_MSG_LEN-1-int'(idx)) +: 8];
            end
        end
        else
        begin
            if (int'(idx) < DIV_MSG_LEN)
            begin
                ch = DIV_MSG[8*(DIV_MSG_LEN-1-int'(idx)) +: 8];
            end
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/integer_calculator_decimal_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_calculator_decimal_out: signed integer calculator with text output
// Request words carry two signed 32-bit operands and an operator byte
// ('+', '-', '*', '/', '%'). Each request yields a line of ASCII text, one
// character per answer word, with last_char set on the closing newline.
// Results wrap to 32 bits; division truncates and the remainder follows the
// dividend's sign. A zero divisor yields a stop message, an unknown operator
// yields "0".
// Both channels move one word per cycle when valid is high and stall is low.
// A front stage and a two-entry command queue hold three requests while the
// execution unit works on a fourth.
// Divide and modulo first pass through the one-bit-per-cycle divider.
// Reset empties the queue, the holding register and the output word.
// While the receiver stalls, the output word holds and the unit waits
// before presenting its next character.
// ----------------------------------------------------------------------------
module integer_calculator_decimal_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire icdo_pkg::req_word_t req,
    output logic                     chr_valid,
    input  wire logic                chr_stall,
    output icdo_pkg::chr_word_t      chr
);
    import icdo_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    cmd_t pop_cmd;
    logic nonempty;

    // Intake and classification.
    icdo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full)
    );

    // Command queue.
    icdo_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .nonempty (nonempty)
    );

    // Execution and text output.
    icdo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_cmd   (pop_cmd),
        .nonempty  (nonempty),
        .pop       (pop),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr       (chr)
    );

endmodule
`default_nettype wire

// ===== rtl/icdo_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icdo_front: request intake and classification
// Takes request words, decodes the operator and zero-divisor cases into a
// command kind, and holds the command until the queue takes it.
// ----------------------------------------------------------------------------
module icdo_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire icdo_pkg::req_word_t req,
    output logic                    push,
    output icdo_pkg::cmd_t          push_cmd,
    input  wire logic               q_full
);
    import icdo_pkg::*;

    logic       cmd_valid_reg;
    logic       cmd_valid_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic       take;
    logic       b_zero;
    logic [2:0] kind;

    // Decode the operator byte into a command kind.
    assign b_zero = (req.second_operand == 32'sd0);

    always_comb
    begin
        unique case (req.func)
            OP_ADD: kind = K_ADD;
            OP_SUB: kind = K_SUB;
            OP_MUL: kind = K_MUL;
            OP_DIV: kind = b_zero ? K_DIVZ : K_DIV;
            OP_MOD: kind = b_zero ? K_MODZ : K_MOD;
            default: kind = K_BAD;
        endcase
    end

    // The holding register empties into the queue whenever it has room.
    assign push      = cmd_valid_reg && !q_full;
    assign push_cmd  = cmd_reg;
    assign req_stall = cmd_valid_reg && q_full;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        if (push)
        begin
            cmd_valid_next = 1'b0;
        end
        if (take)
        begin
            cmd_valid_next = 1'b1;
            cmd_next.kind  = kind;
            cmd_next.a     = req.first_operand;
            cmd_next.b     = req.second_operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule
`default_nettype wire

// ===== rtl/icdo_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icdo_queue: command queue between front end and execution unit
// A small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module icdo_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire icdo_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output icdo_pkg::cmd_t      pop_cmd,
    output logic                nonempty
);
    import icdo_pkg::*;

    cmd_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]     wr_ptr_reg;
    logic [QUEUE_PW-1:0]     wr_ptr_next;
    logic [QUEUE_PW-1:0]     rd_ptr_reg;
    logic [QUEUE_PW-1:0]     rd_ptr_next;
    logic [QUEUE_PW:0]       count_reg;
    logic [QUEUE_PW:0]       count_next;

    assign full     = (count_reg == (QUEUE_PW+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_cmd  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PW'(QUEUE_DEPTH-1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PW'(QUEUE_DEPTH-1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/icdo_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icdo_back: execution unit and text emitter
// Runs one command at a time: arithmetic, a one-bit-per-cycle restoring
// divider, decimal conversion one digit per multiply and subtract state pair,
// and character output through a registered word stage.
// ----------------------------------------------------------------------------
module icdo_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire icdo_pkg::cmd_t pop_cmd,
    input  wire logic           nonempty,
    output logic                pop,
    output logic                chr_valid,
    input  wire logic           chr_stall,
    output icdo_pkg::chr_word_t chr
);
    import icdo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_FIX  = 4'd2;
    localparam logic [3:0] S_SIGN = 4'd3;
    localparam logic [3:0] S_DMUL = 4'd4;
    localparam logic [3:0] S_DSUB = 4'd5;
    localparam logic [3:0] S_EMIT = 4'd6;
    localparam logic [3:0] S_MSG  = 4'd7;
    localparam logic [3:0] S_ZERO = 4'd8;
    localparam logic [3:0] S_NL   = 4'd9;

    localparam int CW = $clog2(DIG_MAX + 1);
    localparam int DW = $clog2(DIG_MAX);

    logic [3:0]    state_reg, state_next;
    logic [31:0]   quo_reg, quo_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   dsr_reg, dsr_next;
    logic [4:0]    bit_cnt_reg, bit_cnt_next;
    logic          neg_q_reg, neg_q_next;
    logic          neg_r_reg, neg_r_next;
    logic          is_mod_reg, is_mod_next;
    logic [31:0]   res_reg, res_next;
    logic [31:0]   mag_reg, mag_next;
    logic [64:0]   prod_reg, prod_next;
    logic [3:0]    digits_reg [DIG_MAX];
    logic [3:0]    digits_next [DIG_MAX];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [4:0]    msg_idx_reg, msg_idx_next;
    logic          chr_valid_reg, chr_valid_next;
    chr_word_t     chr_reg, chr_next;

    logic          out_free;
    logic [32:0]   rem_sh;
    logic [32:0]   trial;
    logic [31:0]   q32;
    logic [31:0]   ten_q;
    logic [31:0]   dig_diff;
    logic [4:0]    msg_last;

    assign chr_valid = chr_valid_reg;
    assign chr       = chr_reg;
    assign out_free  = !chr_valid_reg || !chr_stall;

    // Divider step and digit arithmetic.
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign trial    = rem_sh - {1'b0, dsr_reg};
    assign q32      = {2'b00, prod_reg[64:RECIP_SH]};
    assign ten_q    = {q32[28:0], 3'b000} + {q32[30:0], 1'b0};
    assign dig_diff = mag_reg - ten_q;
    assign msg_last = is_mod_reg ? 5'(MOD_MSG_LEN - 1) : 5'(DIV_MSG_LEN - 1);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        bit_cnt_next   = bit_cnt_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        is_mod_next    = is_mod_reg;
        res_next       = res_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        digits_next    = digits_reg;
        cnt_next       = cnt_reg;
        msg_idx_next   = msg_idx_reg;
        chr_valid_next = chr_valid_reg && chr_stall;
        chr_next       = chr_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (nonempty)
                begin
                    pop = 1'b1;
                    unique case (pop_cmd.kind)
                        K_ADD:
                        begin
                            res_next   = pop_cmd.a + pop_cmd.b;
                            state_next = S_SIGN;
                        end
                        K_SUB:
                        begin
                            res_next   = pop_cmd.a - pop_cmd.b;
                            state_next = S_SIGN;
                        end
                        K_MUL:
                        begin
                            res_next   = pop_cmd.a * pop_cmd.b;
                            state_next = S_SIGN;
                        end
                        K_DIV, K_MOD:
                        begin
                            quo_next     = pop_cmd.a[31] ? (~pop_cmd.a + 32'd1) : pop_cmd.a;
                            dsr_next     = pop_cmd.b[31] ? (~pop_cmd.b + 32'd1) : pop_cmd.b;
                            rem_next     = '0;
                            bit_cnt_next = '0;
                            neg_q_next   = pop_cmd.a[31] ^ pop_cmd.b[31];
                            neg_r_next   = pop_cmd.a[31];
                            is_mod_next  = (pop_cmd.kind == K_MOD);
                            state_next   = S_DIV;
                        end
                        K_DIVZ, K_MODZ:
                        begin
                            is_mod_next  = (pop_cmd.kind == K_MODZ);
                            msg_idx_next = '0;
                            state_next   = S_MSG;
                        end
                        default:
                        begin
                            state_next = S_ZERO;
                        end
                    endcase
                end
            end

            // One quotient bit per cycle on the magnitudes.
            S_DIV:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31)
                begin
                    state_next = S_FIX;
                end
            end

            // Restore signs: quotient by operand signs, remainder by dividend.
            S_FIX:
            begin
                if (is_mod_reg)
                begin
                    res_next = neg_r_reg ? (~rem_reg + 32'd1) : rem_reg;
                end
                else
                begin
                    res_next = neg_q_reg ? (~quo_reg + 32'd1) : quo_reg;
                end
                state_next = S_SIGN;
            end

            // Emit the minus sign if needed and take the magnitude.
            S_SIGN:
            begin
                mag_next = res_reg[31] ? (~res_reg + 32'd1) : res_reg;
                cnt_next = '0;
                if (!res_reg[31])
                begin
                    state_next = S_DMUL;
                end
                else if (out_free)
                begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_char  = CH_MINUS;
                    chr_next.last_char = 1'b0;
                    state_next         = S_DMUL;
                end
            end

            // Quotient by ten through the reciprocal product.
            S_DMUL:
            begin
                prod_next  = mag_reg * RECIP10;
                state_next = S_DSUB;
            end

            // Store the low digit and continue with the quotient.
            S_DSUB:
            begin
                digits_next[cnt_reg[DW-1:0]] = dig_diff[3:0];
                cnt_next = cnt_reg + 1'b1;
                mag_next = q32;
                if ((q32 == '0) || (cnt_reg == CW'(DIG_MAX - 1)))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DMUL;
                end
            end

            // Digits leave most significant first.
            S_EMIT:
            begin
                if (out_free)
                begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_char  = CH_ZERO + {4'd0, digits_reg[DW'(cnt_reg - 1'b1)]};
                    chr_next.last_char = 1'b0;
                    cnt_next           = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = S_NL;
                    end
                end
            end

            S_MSG:
            begin
                if (out_free)
                begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_char  = msg_char(is_mod_reg, msg_idx_reg);
                    chr_next.last_char = 1'b0;
                    msg_idx_next       = msg_idx_reg + 5'd1;
                    if (msg_idx_reg == msg_last)
                    begin
                        state_next = S_NL;
                    end
                end
            end

            S_ZERO:
            begin
                if (out_free)
                begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_char  = CH_ZERO;
                    chr_next.last_char = 1'b0;
                    state_next         = S_NL;
                end
            end

            S_NL:
            begin
                if (out_free)
                begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_char  = CH_NEWLINE;
                    chr_next.last_char = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chr_valid_reg <= chr_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        bit_cnt_reg <= bit_cnt_next;
        neg_q_reg   <= neg_q_next;
        neg_r_reg   <= neg_r_next;
        is_mod_reg  <= is_mod_next;
        res_reg     <= res_next;
        mag_reg     <= mag_next;
        prod_reg    <= prod_next;
        digits_reg  <= digits_next;
        cnt_reg     <= cnt_next;
        msg_idx_reg <= msg_idx_next;
        chr_reg     <= chr_next;
    end

endmodule
`default_nettype wire

// ===== sim/integer_calculator_decimal_out_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_calculator_decimal_out_tb: self-checking bench for the calculator
// Sends request words with two signed operands and an operator byte, works
// out the answer text of each accepted request on its own, and compares every
// character word that comes back, in order, against that text. Both sides
// insert random gaps, with one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module integer_calculator_decimal_out_tb;

    import icdo_pkg::*;

    // Cycles with no word moving on either side before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;
    // Cycles left to run after the last expected character has come.
    localparam int TAIL_CYCLES = 80;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      chr_valid;
    logic      chr_stall;
    chr_word_t chr;

    // Characters still owed by the block, oldest first.
    chr_word_t expected_text[$];
    int        error_count;
    int        idle_cycles;
    bit        steady_source;
    bit        steady_sink;

    integer_calculator_decimal_out dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr       (chr)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Appends one character to the expected answer text.
    function automatic void push_char(input logic [7:0] c, input logic last);
        chr_word_t w;
        w.out_char  = c;
        w.last_char = last;
        expected_text.push_back(w);
    endfunction

    // Works out the full answer line of one request and queues it.
    function automatic void queue_answer_text(input req_word_t w);
        longint      a;
        longint      b;
        longint      q;
        logic [31:0] value;
        logic [31:0] mag;
        logic [7:0]  digits [0:9];
        int          cnt;
        bit          numeric;
        string       msg;
        a = longint'($signed(w.first_operand));
        b = longint'($signed(w.second_operand));
        numeric = 1'b1;
        value = '0;
        msg = "";
        case (w.func)
            OP_ADD: value = w.first_operand + w.second_operand;
            OP_SUB: value = w.first_operand - w.second_operand;
            OP_MUL: value = w.first_operand * w.second_operand;
            OP_DIV:
            begin
                if (b == 0)
                begin
                    numeric = 1'b0;
                    msg = "Stop : division by zero";
                end
                else
                begin
                    // 64-bit quotient, so the most negative over minus one wraps cleanly.
                    q = a / b;
                    value = q[31:0];
                end
            end
            OP_MOD:
            begin
                if (b == 0)
                begin
                    numeric = 1'b0;
                    msg = "Stop : modulo by zero";
                end
                else
                begin
                    q = a % b;
                    value = q[31:0];
                end
            end
            // An unknown operator answers with a plain zero.
            default: value = '0;
        endcase
        if (numeric)
        begin
            mag = value;
            if (value[31])
            begin
                push_char(CH_MINUS, 1'b0);
                mag = ~value + 32'd1;
            end
            // Digits come out least significant first and are sent in reverse.
            cnt = 0;
            do
            begin
                digits[cnt] = CH_ZERO + 8'(mag % 32'd10);
                mag = mag / 32'd10;
                cnt++;
            end
            while (mag != 0 && cnt < 10);
            while (cnt > 0)
            begin
                cnt--;
                push_char(digits[cnt], 1'b0);
            end
        end
        else
        begin
            for (int i = 0; i < msg.len(); i++)
            begin
                push_char(msg[i], 1'b0);
            end
        end
        push_char(CH_NEWLINE, 1'b1);
    endfunction

    // Operand drawn from small values, mid-size values, both extremes or all bits.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 200) - 100;
            1: v = $urandom_range(0, 99999);
            2: v = MOST_NEG + $urandom_range(0, 15);
            3: v = MOST_POS - $urandom_range(0, 15);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Operator byte: mostly the five known ones, sometimes any byte at all.
    function automatic logic [7:0] pick_func();
        logic [7:0] f;
        case ($urandom_range(0, 11))
            0, 1: f = OP_ADD;
            2, 3: f = OP_SUB;
            4, 5: f = OP_MUL;
            6, 7: f = OP_DIV;
            8, 9: f = OP_MOD;
            default: f = 8'($urandom());
        endcase
        return f;
    endfunction

    // Sends one request word after a random gap and records its answer.
    task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                                input logic [7:0] f);
        req_word_t w;
        int        gap;
        w.first_operand  = a;
        w.second_operand = b;
        w.func           = f;
        gap = steady_source ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        queue_answer_text(w);
    endtask

    // Holds the request side quiet until every owed character has come back.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge clk);
    endtask

    // Operand and operator corners, each stop message and unknown operators.
    task automatic test_directed_cases();
        send_request(MOST_NEG, MOST_NEG, OP_ADD);
        send_request(MOST_POS, 32'd1, OP_ADD);
        send_request(MINUS_ONE, 32'd0, OP_ADD);
        send_request(32'd1000000000, 32'd0, OP_ADD);
        send_request(MOST_NEG, 32'd1, OP_SUB);
        send_request(32'd0, MOST_POS, OP_SUB);
        send_request(MOST_POS, MINUS_ONE, OP_SUB);
        send_request(MOST_POS, MOST_POS, OP_MUL);
        send_request(MOST_NEG, MINUS_ONE, OP_MUL);
        send_request(32'd123456, -32'sd7, OP_MUL);
        send_request(MOST_NEG, MINUS_ONE, OP_DIV);
        send_request(MOST_NEG, MINUS_ONE, OP_MOD);
        send_request(MOST_POS, 32'd1, OP_DIV);
        send_request(-32'sd7, 32'd2, OP_DIV);
        send_request(32'd7, -32'sd2, OP_DIV);
        send_request(-32'sd7, 32'd2, OP_MOD);
        send_request(32'd7, -32'sd2, OP_MOD);
        send_request(32'd5, 32'd0, OP_DIV);
        send_request(MOST_NEG, 32'd0, OP_MOD);
        send_request(32'd0, 32'd0, OP_DIV);
        send_request(32'd0, 32'd0, OP_MOD);
        send_request(MOST_POS, MOST_NEG, 8'h00);
        send_request(32'd42, 32'd42, 8'hFF);
        send_request(32'd1, 32'd2, 8'h2C);
    endtask

    // Random requests with random gaps; a drain pause partway through.
    task automatic test_random_mixed(input int count);
        logic [31:0] b;
        for (int i = 0; i < count; i++)
        begin
            b = ($urandom_range(0, 7) == 0) ? 32'd0 : pick_operand();
            send_request(pick_operand(), b, pick_func());
            if (i == count / 2)
            begin
                wait_for_drain();
            end
        end
    endtask

    // Back-to-back requests against a sink that never stalls.
    task automatic test_back_to_back(input int count);
        steady_source = 1'b1;
        steady_sink   = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            send_request(pick_operand(), pick_operand(), pick_func());
        end
        wait_for_drain();
        steady_source = 1'b0;
        steady_sink   = 1'b0;
    endtask

    // Answer side stall: a random wait before each word, then ready until it moves.
    initial
    begin
        int gap;
        chr_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = steady_sink ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                chr_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            chr_stall <= 1'b0;
            do @(posedge clk); while (!chr_valid);
        end
    end

    // Compares each accepted character word with the oldest one owed.
    always @(posedge clk)
    begin
        chr_word_t want;
        if (rst_n && chr_valid && !chr_stall)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected word: out_char %h last_char %b", chr.out_char,
                       chr.last_char);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (chr.out_char !== want.out_char)
                begin
                    $error("out_char expected %h actual %h", want.out_char, chr.out_char);
                    error_count++;
                end
                if (chr.last_char !== want.last_char)
                begin
                    $error("last_char expected %b actual %b", want.last_char,
                           chr.last_char);
                    error_count++;
                end
            end
        end
    end

    // Ends a run in which no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (chr_valid && !chr_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("integer_calculator_decimal_out_tb: errors");
                $finish;
            end
        end
    end

    // Reset, then the tests in turn, then the final verdict.
    initial
    begin
        error_count   = 0;
        idle_cycles   = 0;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        rst_n         = 1'b0;
        req_valid    <= 1'b0;
        req          <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_mixed(246);
        test_back_to_back(40);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("integer_calculator_decimal_out_tb: clean");
        end
        else
        begin
            $display("integer_calculator_decimal_out_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/icdo_pkg.sv
rtl/icdo_front.sv
rtl/icdo_queue.sv
rtl/icdo_back.sv
rtl/integer_calculator_decimal_out.sv
sim/integer_calculator_decimal_out_tb.sv
